// File: hw/rtl/idl_pkg.sv
// ----------------------------------------------------------------------------
// idl_pkg
// Shared types, codes and constants for the indexed doubly linked list block.
// ----------------------------------------------------------------------------
package idl_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int ID_W       = 10;
   localparam int COUNT_W    = 11;
   localparam int OP_W       = 3;
   localparam int STEP_W     = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
   localparam logic [OP_W-1:0] OP_SWAP       = 3'd2;
   localparam logic [OP_W-1:0] OP_TOGGLE     = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_FIRST = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_NEXT  = 3'd5;

   // Datapath step codes issued by the controller
   localparam logic [STEP_W-1:0] STEP_NONE       = 5'd0;
   localparam logic [STEP_W-1:0] STEP_LOAD       = 5'd1;
   localparam logic [STEP_W-1:0] STEP_READ_PAIR  = 5'd2;
   localparam logic [STEP_W-1:0] STEP_INS_EMPTY  = 5'd3;
   localparam logic [STEP_W-1:0] STEP_INS_LINK   = 5'd4;
   localparam logic [STEP_W-1:0] STEP_INS_CLOSE  = 5'd5;
   localparam logic [STEP_W-1:0] STEP_REM        = 5'd6;
   localparam logic [STEP_W-1:0] STEP_CLEAR      = 5'd7;
   localparam logic [STEP_W-1:0] STEP_TOGGLE     = 5'd8;
   localparam logic [STEP_W-1:0] STEP_SW_FIRST   = 5'd9;
   localparam logic [STEP_W-1:0] STEP_SW_A_LEFT  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_SW_READ_B  = 5'd11;
   localparam logic [STEP_W-1:0] STEP_SW_A_RIGHT = 5'd12;
   localparam logic [STEP_W-1:0] STEP_SW_B_LEFT  = 5'd13;
   localparam logic [STEP_W-1:0] STEP_SW_B_RIGHT = 5'd14;
   localparam logic [STEP_W-1:0] STEP_READ_OUT   = 5'd15;
   localparam logic [STEP_W-1:0] STEP_EMIT       = 5'd16;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic [ID_W-1:0] node;
      logic [ID_W-1:0] anchor;
      logic            side;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    node_id;
      logic [COUNT_W-1:0] length;
      logic               read_valid;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            count_zero;
      logic            walk_ok;
      logic            out_free;
   } status_type;

endpackage

// File: hw/rtl/idl_ram.sv
// ----------------------------------------------------------------------------
// idl_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module idl_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/idl_ctrl.sv
// ----------------------------------------------------------------------------
// idl_ctrl
// Sequencer that walks each operation through its link table steps.
// ----------------------------------------------------------------------------
module idl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  idl_pkg::status_type status,
   output idl_pkg::cmd_type    cmd
);
   import idl_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_INS1   = 4'd2;
   localparam logic [3:0] ST_INS2   = 4'd3;
   localparam logic [3:0] ST_REM1   = 4'd4;
   localparam logic [3:0] ST_SW1    = 4'd5;
   localparam logic [3:0] ST_SW2    = 4'd6;
   localparam logic [3:0] ST_SW3    = 4'd7;
   localparam logic [3:0] ST_SW4    = 4'd8;
   localparam logic [3:0] ST_SW5    = 4'd9;
   localparam logic [3:0] ST_SW6    = 4'd10;
   localparam logic [3:0] ST_RD1    = 4'd11;
   localparam logic [3:0] ST_DONE   = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.step = STEP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.step = STEP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            case (status.op)
               OP_INSERT: begin
                  if (status.count_zero) begin
                     cmd.step = STEP_INS_EMPTY;
                  end else begin
                     cmd.step = STEP_READ_PAIR;
                     state_in = ST_INS1;
                  end
               end
               OP_REMOVE: begin
                  if (status.count_zero) begin
                     cmd.step = STEP_CLEAR;
                  end else begin
                     cmd.step = STEP_READ_PAIR;
                     state_in = ST_REM1;
                  end
               end
               OP_SWAP: begin
                  cmd.step = STEP_READ_PAIR;
                  state_in = ST_SW1;
               end
               OP_TOGGLE: begin
                  cmd.step = STEP_TOGGLE;
               end
               OP_READ_FIRST: begin
                  if (status.count_zero) begin
                     cmd.step = STEP_CLEAR;
                  end else begin
                     cmd.step = STEP_READ_PAIR;
                     state_in = ST_RD1;
                  end
               end
               OP_READ_NEXT: begin
                  if (status.walk_ok) begin
                     cmd.step = STEP_READ_PAIR;
                     state_in = ST_RD1;
                  end
               end
               default: begin
                  cmd.step = STEP_NONE;
               end
            endcase
         end
         ST_INS1: begin
            cmd.step = STEP_INS_LINK;
            state_in = ST_INS2;
         end
         ST_INS2: begin
            cmd.step = STEP_INS_CLOSE;
            state_in = ST_DONE;
         end
         ST_REM1: begin
            cmd.step = STEP_REM;
            state_in = ST_DONE;
         end
         ST_SW1: begin
            cmd.step = STEP_SW_FIRST;
            state_in = ST_SW2;
         end
         ST_SW2: begin
            cmd.step = STEP_SW_A_LEFT;
            state_in = ST_SW3;
         end
         ST_SW3: begin
            cmd.step = STEP_SW_READ_B;
            state_in = ST_SW4;
         end
         ST_SW4: begin
            cmd.step = STEP_SW_A_RIGHT;
            state_in = ST_SW5;
         end
         ST_SW5: begin
            cmd.step = STEP_SW_B_LEFT;
            state_in = ST_SW6;
         end
         ST_SW6: begin
            cmd.step = STEP_SW_B_RIGHT;
            state_in = ST_DONE;
         end
         ST_RD1: begin
            cmd.step = STEP_READ_OUT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.step = STEP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/idl_datapath.sv
// ----------------------------------------------------------------------------
// idl_datapath
// Link tables, list registers and result register, driven step by step.
// ----------------------------------------------------------------------------
module idl_datapath (
   input  logic                clock,
   input  logic                reset,
   input  idl_pkg::req_type    req_data,
   input  idl_pkg::cmd_type    cmd,
   output idl_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output idl_pkg::rsp_type    rsp_data
);
   import idl_pkg::*;

   // Link tables: left and right neighbour of every node id
   logic            l_wr_en, r_wr_en, l_rd_en, r_rd_en;
   logic [ID_W-1:0] l_wr_addr, r_wr_addr, l_rd_addr, r_rd_addr;
   logic [ID_W-1:0] l_wr_data, r_wr_data, l_rd_data, r_rd_data;

   idl_ram #(.DEPTH(NODE_COUNT), .WIDTH(ID_W)) u_left_links (
      .clock   (clock),
      .wr_en   (l_wr_en),
      .wr_addr (l_wr_addr),
      .wr_data (l_wr_data),
      .rd_en   (l_rd_en),
      .rd_addr (l_rd_addr),
      .rd_data (l_rd_data)
   );

   idl_ram #(.DEPTH(NODE_COUNT), .WIDTH(ID_W)) u_right_links (
      .clock   (clock),
      .wr_en   (r_wr_en),
      .wr_addr (r_wr_addr),
      .wr_data (r_wr_data),
      .rd_en   (r_rd_en),
      .rd_addr (r_rd_addr),
      .rd_data (r_rd_data)
   );

   req_type            item_ff, item_in;
   logic [ID_W-1:0]    head_ff, head_in;
   logic [ID_W-1:0]    tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rev_ff, rev_in;
   logic [ID_W-1:0]    cursor_ff, cursor_in;
   logic [COUNT_W-1:0] walk_ff, walk_in;
   logic [ID_W-1:0]    sl_ff, sl_in;
   logic [ID_W-1:0]    sr_ff, sr_in;
   logic [ID_W-1:0]    res_node_ff, res_node_in;
   logic               res_valid_ff, res_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [ID_W-1:0]    first_id;
   logic               side_eff;
   logic [COUNT_W-1:0] count_inc;

   assign first_id  = rev_ff ? tail_ff : head_ff;
   assign side_eff  = item_ff.side ^ rev_ff;
   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;

   assign status.op         = item_ff.operation;
   assign status.count_zero = (count_ff == '0);
   assign status.walk_ok    = (walk_ff != '0) && (walk_ff < count_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      item_in      = item_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rev_in       = rev_ff;
      cursor_in    = cursor_ff;
      walk_in      = walk_ff;
      sl_in        = sl_ff;
      sr_in        = sr_ff;
      res_node_in  = res_node_ff;
      res_valid_in = res_valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      l_wr_en      = 1'b0;
      r_wr_en      = 1'b0;
      l_rd_en      = 1'b0;
      r_rd_en      = 1'b0;
      l_wr_addr    = item_ff.node;
      r_wr_addr    = item_ff.node;
      l_wr_data    = item_ff.node;
      r_wr_data    = item_ff.node;
      l_rd_addr    = item_ff.anchor;
      r_rd_addr    = item_ff.anchor;

      case (cmd.step)
         STEP_LOAD: begin
            item_in      = req_data;
            res_node_in  = '0;
            res_valid_in = 1'b0;
         end
         STEP_READ_PAIR: begin
            l_rd_en = 1'b1;
            r_rd_en = 1'b1;
            case (item_ff.operation)
               OP_INSERT: begin
                  l_rd_addr = item_ff.anchor;
               end
               OP_REMOVE, OP_SWAP: begin
                  l_rd_addr = item_ff.node;
               end
               OP_READ_FIRST: begin
                  l_rd_addr = first_id;
               end
               default: begin
                  l_rd_addr = cursor_ff;
               end
            endcase
            r_rd_addr = l_rd_addr;
         end
         STEP_INS_EMPTY: begin
            l_wr_en  = 1'b1;
            r_wr_en  = 1'b1;
            head_in  = item_ff.node;
            tail_in  = item_ff.node;
            count_in = count_inc;
            walk_in  = '0;
         end
         STEP_INS_LINK: begin
            // The neighbour on the chosen side now points back at the new node.
            l_wr_en = 1'b1;
            r_wr_en = 1'b1;
            if (!side_eff) begin
               r_wr_addr = l_rd_data;
               r_wr_data = item_ff.node;
               l_wr_addr = item_ff.node;
               l_wr_data = l_rd_data;
            end else begin
               l_wr_addr = r_rd_data;
               l_wr_data = item_ff.node;
               r_wr_addr = item_ff.node;
               r_wr_data = r_rd_data;
            end
         end
         STEP_INS_CLOSE: begin
            l_wr_en = 1'b1;
            r_wr_en = 1'b1;
            if (!side_eff) begin
               r_wr_addr = item_ff.node;
               r_wr_data = item_ff.anchor;
               l_wr_addr = item_ff.anchor;
               l_wr_data = item_ff.node;
               if (head_ff == item_ff.anchor) begin
                  head_in = item_ff.node;
               end
            end else begin
               l_wr_addr = item_ff.node;
               l_wr_data = item_ff.anchor;
               r_wr_addr = item_ff.anchor;
               r_wr_data = item_ff.node;
               if (tail_ff == item_ff.anchor) begin
                  tail_in = item_ff.node;
               end
            end
            count_in = count_inc;
            walk_in  = '0;
         end
         STEP_REM: begin
            l_wr_en   = 1'b1;
            r_wr_en   = 1'b1;
            r_wr_addr = l_rd_data;
            r_wr_data = r_rd_data;
            l_wr_addr = r_rd_data;
            l_wr_data = l_rd_data;
            if (head_ff == item_ff.node) begin
               head_in = r_rd_data;
            end
            if (tail_ff == item_ff.node) begin
               tail_in = l_rd_data;
            end
            count_in = count_ff - COUNT_W'(1);
            walk_in  = '0;
         end
         STEP_CLEAR: begin
            walk_in = '0;
         end
         STEP_TOGGLE: begin
            rev_in  = !rev_ff;
            walk_in = '0;
         end
         STEP_SW_FIRST: begin
            // Keep both original neighbours of the first node, then fetch the
            // left neighbour of the second node.
            sl_in     = l_rd_data;
            sr_in     = r_rd_data;
            l_rd_en   = 1'b1;
            l_rd_addr = item_ff.anchor;
            if (head_ff == item_ff.node) begin
               head_in = item_ff.anchor;
            end else if (head_ff == item_ff.anchor) begin
               head_in = item_ff.node;
            end
            if (tail_ff == item_ff.node) begin
               tail_in = item_ff.anchor;
            end else if (tail_ff == item_ff.anchor) begin
               tail_in = item_ff.node;
            end
            walk_in = '0;
         end
         STEP_SW_A_LEFT: begin
            r_wr_en   = (l_rd_data != item_ff.node);
            r_wr_addr = l_rd_data;
            r_wr_data = item_ff.node;
            l_wr_en   = 1'b1;
            l_wr_addr = item_ff.node;
            l_wr_data = (l_rd_data != item_ff.node) ? l_rd_data : item_ff.anchor;
         end
         STEP_SW_READ_B: begin
            // Read after the previous right link write, which may have hit it.
            r_rd_en   = 1'b1;
            r_rd_addr = item_ff.anchor;
         end
         STEP_SW_A_RIGHT: begin
            l_wr_en   = (r_rd_data != item_ff.node);
            l_wr_addr = r_rd_data;
            l_wr_data = item_ff.node;
            r_wr_en   = 1'b1;
            r_wr_addr = item_ff.node;
            r_wr_data = (r_rd_data != item_ff.node) ? r_rd_data : item_ff.anchor;
         end
         STEP_SW_B_LEFT: begin
            r_wr_en   = (sl_ff != item_ff.anchor);
            r_wr_addr = sl_ff;
            r_wr_data = item_ff.anchor;
            l_wr_en   = 1'b1;
            l_wr_addr = item_ff.anchor;
            l_wr_data = (sl_ff != item_ff.anchor) ? sl_ff : item_ff.node;
         end
         STEP_SW_B_RIGHT: begin
            l_wr_en   = (sr_ff != item_ff.anchor);
            l_wr_addr = sr_ff;
            l_wr_data = item_ff.anchor;
            r_wr_en   = 1'b1;
            r_wr_addr = item_ff.anchor;
            r_wr_data = (sr_ff != item_ff.anchor) ? sr_ff : item_ff.node;
         end
         STEP_READ_OUT: begin
            res_valid_in = 1'b1;
            cursor_in    = rev_ff ? l_rd_data : r_rd_data;
            if (item_ff.operation == OP_READ_FIRST) begin
               res_node_in = first_id;
               walk_in     = COUNT_W'(1);
            end else begin
               res_node_in = cursor_ff;
               walk_in     = walk_ff + COUNT_W'(1);
            end
         end
         STEP_EMIT: begin
            rsp_in.node_id    = res_node_ff;
            rsp_in.length     = count_ff;
            rsp_in.read_valid = res_valid_ff;
            rsp_valid_in      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         cursor_ff    <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         cursor_ff    <= cursor_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      sl_ff        <= sl_in;
      sr_ff        <= sr_in;
      res_node_ff  <= res_node_in;
      res_valid_ff <= res_valid_in;
      rsp_ff       <= rsp_in;
   end

endmodule

// File: hw/rtl/indexed_doubly_linked_list_top.sv
// Circular doubly linked list of up to 1024 node ids, held as left and right
// link tables with head, tail, length and a reversal flag. One transaction is
// taken at a time and gives exactly one result transaction; the next request
// is accepted while that result still waits on a stalled output. A toggle,
// an unused code, a next read that cannot go on, or an insert, remove or
// first read on an empty list is settled in the decode step; every other
// operation adds link table steps before the result register is loaded. Each
// table does one access per cycle and returns read data in the cycle after the
// address, so the link reads and rewrites of an operation are spread over
// successive sequencer steps. The tables need no clearing pass.
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top
// Top level: controller, datapath and link tables of the linked list block.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  idl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output idl_pkg::rsp_type rsp_data
);
   import idl_pkg::*;

   cmd_type    cmd;
   status_type status;

   idl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   idl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: test/indexed_doubly_linked_list_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top_test
// Self-checking bench for the linked list block. Request transactions are
// queued by a generator that takes anchors and removed or swapped nodes from
// the current members while there are any. A clocked driver and a clocked
// monitor move them under four pacing mixes. A behavioural copy of the list
// predicts every response, and each response is compared field by field.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_top_test;
   import idl_pkg::*;

   // Operation codes that the block leaves unused.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   indexed_doubly_linked_list_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Behavioural copy of the list, advanced once per accepted request.
   bit [ID_W-1:0]    link_left  [NODE_COUNT];
   bit [ID_W-1:0]    link_right [NODE_COUNT];
   bit [ID_W-1:0]    list_head;
   bit [ID_W-1:0]    list_tail;
   bit [COUNT_W-1:0] list_len;
   bit               list_rev;
   bit [ID_W-1:0]    walk_pos;
   bit [COUNT_W-1:0] walk_done;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   rsp_type want_rsp;

   // Generator bookkeeping: which ids are in the list.
   bit in_set     [NODE_COUNT];
   int members    [$];
   int items_queued;

   int send_idle_pct;
   int rsp_stall_pct;
   int errors;
   int items_accepted;
   int results_checked;
   int reads_returned;
   int longest_list;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("indexed_doubly_linked_list_top_test: errors");
      $finish;
   end

   function automatic rsp_type next_list_response(input req_type r);
      rsp_type          res;
      logic [ID_W-1:0]  n;
      logic [ID_W-1:0]  a;
      logic [ID_W-1:0]  l;
      logic [ID_W-1:0]  rt;
      logic [ID_W-1:0]  t;
      logic [ID_W-1:0]  first;
      res = '0;
      n = r.node;
      a = r.anchor;
      case (r.operation)
         OP_INSERT: begin
            if (list_len == 0) begin
               list_head = n;
               list_tail = n;
               link_left[n] = n;
               link_right[n] = n;
            end else if ((r.side ^ list_rev) == 1'b0) begin
               l = link_left[a];
               link_right[l] = n;
               link_left[n] = l;
               link_right[n] = a;
               link_left[a] = n;
               if (list_head == a) list_head = n;
            end else begin
               rt = link_right[a];
               link_left[rt] = n;
               link_right[n] = rt;
               link_left[n] = a;
               link_right[a] = n;
               if (list_tail == a) list_tail = n;
            end
            if (list_len != COUNT_MAX) list_len++;
            walk_done = '0;
         end
         OP_REMOVE: begin
            if (list_len != 0) begin
               if (list_head == n) list_head = link_right[n];
               if (list_tail == n) list_tail = link_left[n];
               l = link_left[n];
               rt = link_right[n];
               link_right[l] = rt;
               // The right link of n is read again; the write above leaves it equal to rt.
               link_left[link_right[n]] = link_left[n];
               list_len--;
            end
            walk_done = '0;
         end
         OP_SWAP: begin
            if (list_head == n) list_head = a;
            else if (list_head == a) list_head = n;
            if (list_tail == n) list_tail = a;
            else if (list_tail == a) list_tail = n;
            l = link_left[n];
            rt = link_right[n];
            t = link_left[a];
            if (t != n) begin
               link_right[t] = n;
               link_left[n] = link_left[a];
            end else begin
               link_left[n] = a;
            end
            t = link_right[a];
            if (t != n) begin
               link_left[t] = n;
               link_right[n] = link_right[a];
            end else begin
               link_right[n] = a;
            end
            if (l != a) begin
               link_right[l] = a;
               link_left[a] = l;
            end else begin
               link_left[a] = n;
            end
            if (rt != a) begin
               link_left[rt] = a;
               link_right[a] = rt;
            end else begin
               link_right[a] = n;
            end
            walk_done = '0;
         end
         OP_TOGGLE: begin
            list_rev = ~list_rev;
            walk_done = '0;
         end
         OP_READ_FIRST: begin
            walk_done = '0;
            if (list_len != 0) begin
               first = list_rev ? list_tail : list_head;
               res.node_id = first;
               res.read_valid = 1'b1;
               walk_pos = list_rev ? link_left[first] : link_right[first];
               walk_done = COUNT_W'(1);
            end
         end
         OP_READ_NEXT: begin
            if (walk_done != 0 && walk_done < list_len) begin
               res.node_id = walk_pos;
               res.read_valid = 1'b1;
               walk_pos = list_rev ? link_left[walk_pos] : link_right[walk_pos];
               walk_done++;
            end
         end
         default: ;
      endcase
      res.length = list_len;
      return res;
   endfunction

   // Driver: presents queued requests, holding each one while it is stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(next_list_response(req_data));
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response transaction and paces the result side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected: node_id %0d length %0d read_valid %0d",
                      rsp_data.node_id, rsp_data.length, rsp_data.read_valid);
               errors++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               results_checked++;
               if (rsp_data.node_id !== want_rsp.node_id) begin
                  $error("node_id: expected %0d, actual %0d", want_rsp.node_id,
                         rsp_data.node_id);
                  errors++;
               end
               if (rsp_data.length !== want_rsp.length) begin
                  $error("length: expected %0d, actual %0d", want_rsp.length,
                         rsp_data.length);
                  errors++;
               end
               if (rsp_data.read_valid !== want_rsp.read_valid) begin
                  $error("read_valid: expected %0d, actual %0d", want_rsp.read_valid,
                         rsp_data.read_valid);
                  errors++;
               end
               if (want_rsp.read_valid) reads_returned++;
               if (int'(want_rsp.length) > longest_list) longest_list = int'(want_rsp.length);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic queue_req(input logic [OP_W-1:0] op, input int node, input int anchor,
                            input int side);
      req_type r;
      int      i;
      r.operation = op;
      r.node = node[ID_W-1:0];
      r.anchor = anchor[ID_W-1:0];
      r.side = side[0];
      pending_reqs.push_back(r);
      items_queued++;
      if (op == OP_INSERT) begin
         if (!in_set[node]) begin
            in_set[node] = 1'b1;
            members.push_back(node);
         end
      end else if (op == OP_REMOVE && in_set[node]) begin
         in_set[node] = 1'b0;
         for (i = 0; i < members.size(); i++)
            if (members[i] == node) begin
               members.delete(i);
               break;
            end
      end
   endtask

   function automatic int any_id();
      return $urandom_range(0, NODE_COUNT - 1);
   endfunction

   function automatic int pick_member();
      return members[$urandom_range(0, members.size() - 1)];
   endfunction

   function automatic int fresh_id();
      int id;
      do id = any_id(); while (in_set[id]);
      return id;
   endfunction

   // One well-formed operation or a short read walk; a small share is noise.
   task automatic queue_random_item();
      int roll;
      int k;
      int i;
      int a;
      roll = $urandom_range(0, 99);
      if (roll < 30 && members.size() >= 28) roll = 30;
      if (roll >= 30 && roll < 45 && members.size() < 3 && $urandom_range(0, 1)) roll = 0;
      if (roll >= 45 && roll < 58 && members.size() == 0) roll = 0;
      if (roll < 30) begin
         queue_req(OP_INSERT, fresh_id(), members.size() != 0 ? pick_member() : any_id(),
                   $urandom_range(0, 1));
      end else if (roll < 45) begin
         // With the list empty this is a remove that must be ignored.
         queue_req(OP_REMOVE, members.size() != 0 ? pick_member() : any_id(), any_id(),
                   $urandom_range(0, 1));
      end else if (roll < 58) begin
         a = pick_member();
         queue_req(OP_SWAP, a, $urandom_range(0, 9) == 0 ? a : pick_member(),
                   $urandom_range(0, 1));
      end else if (roll < 63) begin
         queue_req(OP_TOGGLE, any_id(), any_id(), $urandom_range(0, 1));
      end else if (roll < 83) begin
         queue_req(OP_READ_FIRST, any_id(), any_id(), $urandom_range(0, 1));
         k = $urandom_range(0, members.size() + 1);
         for (i = 0; i < k; i++) begin
            // Now and then a change cuts the walk short.
            if ($urandom_range(0, 24) == 0)
               queue_req(OP_TOGGLE, any_id(), any_id(), $urandom_range(0, 1));
            queue_req(OP_READ_NEXT, any_id(), any_id(), $urandom_range(0, 1));
         end
      end else if (roll < 91) begin
         queue_req(OP_READ_NEXT, any_id(), any_id(), $urandom_range(0, 1));
      end else begin
         queue_req($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, any_id(), any_id(),
                   $urandom_range(0, 1));
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input int n_items);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      items_queued = 0;
      while (items_queued < n_items) queue_random_item();
      drain();
   endtask

   task automatic queue_directed();
      int i;
      queue_req(OP_READ_FIRST, 0, 0, 0);
      queue_req(OP_READ_NEXT, 1023, 1023, 1);
      queue_req(OP_REMOVE, 1023, 0, 1);
      queue_req(OP_SPARE_LO, 0, 1023, 1);
      queue_req(OP_SPARE_HI, 1023, 0, 0);
      queue_req(OP_INSERT, 0, 1023, 0);
      queue_req(OP_INSERT, 1023, 0, 1);
      queue_req(OP_INSERT, 512, 0, 0);
      queue_req(OP_INSERT, 341, 1023, 1);
      queue_req(OP_INSERT, 682, 341, 0);
      // Whole walk of five nodes and one read past the end.
      queue_req(OP_READ_FIRST, 341, 682, 1);
      for (i = 0; i < 5; i++) queue_req(OP_READ_NEXT, 682, 341, i & 1);
      queue_req(OP_TOGGLE, 0, 0, 0);
      queue_req(OP_INSERT, 85, 512, 1);
      queue_req(OP_READ_FIRST, 0, 0, 0);
      queue_req(OP_READ_NEXT, 0, 0, 0);
      // Adjacent swaps in both orders, then a distant one that moves the head.
      queue_req(OP_SWAP, 512, 0, 0);
      queue_req(OP_SWAP, 341, 682, 1);
      queue_req(OP_SWAP, 85, 1023, 0);
      queue_req(OP_TOGGLE, 1023, 1023, 1);
      queue_req(OP_REMOVE, 1023, 0, 0);
      queue_req(OP_REMOVE, 682, 0, 0);
      queue_req(OP_READ_FIRST, 0, 0, 0);
      queue_req(OP_TOGGLE, 0, 0, 0);
      queue_req(OP_READ_NEXT, 0, 0, 0);
   endtask

   initial begin
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      drain();
      run_phase(0, 0, 125);
      run_phase(55, 0, 125);
      run_phase(0, 55, 125);
      run_phase(37, 37, 125);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (expected_rsps.size() != 0 || pending_reqs.size() != 0) begin
         $error("transactions left over: %0d responses owed, %0d requests unsent",
                expected_rsps.size(), pending_reqs.size());
         errors++;
      end
      $display("Checked %0d responses for %0d requests; %0d reads returned a node.",
               results_checked, items_accepted, reads_returned);
      $display("Paced four ways, with swaps, reversal and a longest length of %0d.",
               longest_list);
      if (errors == 0)
         $display("indexed_doubly_linked_list_top_test: clean");
      else
         $display("indexed_doubly_linked_list_top_test: errors");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/idl_pkg.sv
hw/rtl/idl_ram.sv
hw/rtl/idl_ctrl.sv
hw/rtl/idl_datapath.sv
hw/rtl/indexed_doubly_linked_list_top.sv
test/indexed_doubly_linked_list_top_test.sv
